FILE: rtl/fra_pkg.sv
// Shared types, constants and operation codes of the four-register ALU executor.
package fra_pkg;

  localparam int NUM_REGS  = 4;
  localparam int REG_IDX_W = $clog2(NUM_REGS);
  localparam int DATA_W    = 32;
  localparam int IMM_W     = 16;
  localparam int OPC_W     = 4;
  localparam int MAP_W     = OPC_W * 16;

  localparam logic [MAP_W-1:0] MAP_RESET = 64'hFEDC_BA98_7654_3210;

  typedef enum logic [OPC_W-1:0] {
    OP_ADDR = 4'd0,
    OP_ADDI = 4'd1,
    OP_MULR = 4'd2,
    OP_MULI = 4'd3,
    OP_BANR = 4'd4,
    OP_BANI = 4'd5,
    OP_BORR = 4'd6,
    OP_BORI = 4'd7,
    OP_SETR = 4'd8,
    OP_SETI = 4'd9,
    OP_GTIR = 4'd10,
    OP_GTRI = 4'd11,
    OP_GTRR = 4'd12,
    OP_EQIR = 4'd13,
    OP_EQRI = 4'd14,
    OP_EQRR = 4'd15
  } op_t;

  typedef struct packed {
    logic                 en;
    logic [REG_IDX_W-1:0] idx;
    logic [DATA_W-1:0]    data;
  } rf_wr_t;

endpackage

FILE: rtl/fra_regfile.sv
// Register file memory with reset valid bits and forwarding of the latest write.
module fra_regfile (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         rd_en,
  input  logic [fra_pkg::REG_IDX_W-1:0] rd_a_idx,
  input  logic [fra_pkg::REG_IDX_W-1:0] rd_b_idx,
  input  fra_pkg::rf_wr_t              wr,
  output logic [fra_pkg::DATA_W-1:0]   rd_a_data,
  output logic [fra_pkg::DATA_W-1:0]   rd_b_data
);
  import fra_pkg::*;

  logic [DATA_W-1:0]    mem [NUM_REGS];
  logic [NUM_REGS-1:0]  vld_r;
  logic [DATA_W-1:0]    rd_a_q_r, rd_b_q_r;
  logic                 rd_a_v_r, rd_b_v_r;
  logic [REG_IDX_W-1:0] rd_a_idx_r, rd_b_idx_r;
  logic                 byp_vld_r;
  logic [REG_IDX_W-1:0] byp_idx_r;
  logic [DATA_W-1:0]    byp_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.idx] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_a_q_r   <= mem[rd_a_idx];
      rd_b_q_r   <= mem[rd_b_idx];
      rd_a_idx_r <= rd_a_idx;
      rd_b_idx_r <= rd_b_idx;
    end
    if (wr.en) begin
      byp_idx_r  <= wr.idx;
      byp_data_r <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      rd_a_v_r  <= 1'b0;
      rd_b_v_r  <= 1'b0;
      byp_vld_r <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_a_v_r <= vld_r[rd_a_idx];
        rd_b_v_r <= vld_r[rd_b_idx];
      end
      if (wr.en) begin
        vld_r[wr.idx] <= 1'b1;
        byp_vld_r     <= 1'b1;
      end
    end
  end

  // The last write is always the newest value of its entry, so it may be
  // forwarded whether or not the memory read already saw it.
  always_comb begin
    if (byp_vld_r && (byp_idx_r == rd_a_idx_r)) begin
      rd_a_data = byp_data_r;
    end else begin
      rd_a_data = rd_a_v_r ? rd_a_q_r : '0;
    end
    if (byp_vld_r && (byp_idx_r == rd_b_idx_r)) begin
      rd_b_data = byp_data_r;
    end else begin
      rd_b_data = rd_b_v_r ? rd_b_q_r : '0;
    end
  end

endmodule

FILE: rtl/fra_alu.sv
// Execute unit for the sixteen operations.
module fra_alu (
  input  fra_pkg::op_t               op,
  input  logic [fra_pkg::DATA_W-1:0] ra,
  input  logic [fra_pkg::DATA_W-1:0] rb,
  input  logic [fra_pkg::IMM_W-1:0]  a,
  input  logic [fra_pkg::IMM_W-1:0]  b,
  output logic [fra_pkg::DATA_W-1:0] result
);
  import fra_pkg::*;

  logic [DATA_W-1:0] ia, ib, mul_rhs;
  logic [DATA_W-1:0] prod;

  assign ia      = {{(DATA_W-IMM_W){1'b0}}, a};
  assign ib      = {{(DATA_W-IMM_W){1'b0}}, b};
  assign mul_rhs = (op == OP_MULI) ? ib : rb;
  assign prod    = ra * mul_rhs;

  always_comb begin
    unique case (op)
      OP_ADDR: result = ra + rb;
      OP_ADDI: result = ra + ib;
      OP_MULR: result = prod;
      OP_MULI: result = prod;
      OP_BANR: result = ra & rb;
      OP_BANI: result = ra & ib;
      OP_BORR: result = ra | rb;
      OP_BORI: result = ra | ib;
      OP_SETR: result = ra;
      OP_SETI: result = ia;
      OP_GTIR: result = {{(DATA_W-1){1'b0}}, $signed(ia) > $signed(rb)};
      OP_GTRI: result = {{(DATA_W-1){1'b0}}, $signed(ra) > $signed(ib)};
      OP_GTRR: result = {{(DATA_W-1){1'b0}}, $signed(ra) > $signed(rb)};
      OP_EQIR: result = {{(DATA_W-1){1'b0}}, ia == rb};
      OP_EQRI: result = {{(DATA_W-1){1'b0}}, ra == ib};
      OP_EQRR: result = {{(DATA_W-1){1'b0}}, ra == rb};
      default: result = '0;
    endcase
  end

endmodule

FILE: rtl/four_register_alu_executor.sv
// Path: an accepted word is registered in the execute stage, then its result in the output register.
// Throughput: one instruction per cycle unless out_stall holds the pipeline; the register file has two read ports
// and one write port, and the last write is forwarded to the execute stage.
// Reset: synchronous, active low; all registers read as zero and the opcode
// map returns to the identity map. No clearing pass is needed.
module four_register_alu_executor (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [fra_pkg::OPC_W-1:0]         in_opcode,
  input  logic [fra_pkg::IMM_W-1:0]         in_a,
  input  logic [fra_pkg::IMM_W-1:0]         in_b,
  input  logic [fra_pkg::REG_IDX_W-1:0]     in_c,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [fra_pkg::DATA_W-1:0] out_written_value,
  output logic [fra_pkg::REG_IDX_W-1:0]     out_dest_index,
  output logic signed [fra_pkg::DATA_W-1:0] out_reg_zero,
  input  logic                              cfg_we,
  input  logic [fra_pkg::MAP_W-1:0]         cfg_wdata
);
  import fra_pkg::*;

  logic [MAP_W-1:0]     opcode_map_r;
  logic                 s1_valid_r;
  op_t                  s1_op_r;
  logic [IMM_W-1:0]     s1_a_r, s1_b_r;
  logic [REG_IDX_W-1:0] s1_c_r;
  logic                 out_valid_r;
  logic [DATA_W-1:0]    out_value_r, out_zero_r;
  logic [REG_IDX_W-1:0] out_dest_r;
  logic [DATA_W-1:0]    reg0_r;

  logic              advance, accept, retire;
  logic [DATA_W-1:0] ra, rb, result, zero_nxt;
  rf_wr_t            wr;

  assign advance  = !s1_valid_r || !out_valid_r || !out_stall;
  assign accept   = in_valid && advance;
  assign retire   = s1_valid_r && advance;
  assign in_stall = !advance;

  assign wr.en   = retire;
  assign wr.idx  = s1_c_r;
  assign wr.data = result;

  fra_regfile u_regfile (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (accept),
    .rd_a_idx  (in_a[REG_IDX_W-1:0]),
    .rd_b_idx  (in_b[REG_IDX_W-1:0]),
    .wr        (wr),
    .rd_a_data (ra),
    .rd_b_data (rb)
  );

  fra_alu u_alu (
    .op     (s1_op_r),
    .ra     (ra),
    .rb     (rb),
    .a      (s1_a_r),
    .b      (s1_b_r),
    .result (result)
  );

  assign zero_nxt = (s1_c_r == '0) ? result : reg0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      opcode_map_r <= MAP_RESET;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      reg0_r       <= '0;
    end else begin
      if (cfg_we) begin
        opcode_map_r <= cfg_wdata;
      end
      if (advance) begin
        s1_valid_r <= in_valid;
      end
      if (retire) begin
        out_valid_r <= 1'b1;
        reg0_r      <= zero_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op_r <= op_t'(opcode_map_r[in_opcode*OPC_W +: OPC_W]);
      s1_a_r  <= in_a;
      s1_b_r  <= in_b;
      s1_c_r  <= in_c;
    end
    if (retire) begin
      out_value_r <= result;
      out_dest_r  <= s1_c_r;
      out_zero_r  <= zero_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_written_value = out_value_r;
  assign out_dest_index    = out_dest_r;
  assign out_reg_zero      = out_zero_r;

  // A word written to register zero must show as register zero too.
  a_zero_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_dest_r == '0) |-> out_zero_r == out_value_r)
    else $error("register zero does not match the word written to it");

  // Compares give only 0 or 1.
  a_cmp_bool: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && (s1_op_r == OP_GTIR || s1_op_r == OP_GTRI || s1_op_r == OP_GTRR ||
                   s1_op_r == OP_EQIR || s1_op_r == OP_EQRI || s1_op_r == OP_EQRR)
    |-> result[DATA_W-1:1] == '0)
    else $error("compare result wider than one bit");

  // A held execute word is neither lost nor altered.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |=> s1_valid_r && $stable(s1_c_r) && $stable(s1_op_r))
    else $error("stalled execute word changed");

  // The register zero shadow follows every write to entry zero.
  a_reg0_track: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en && (wr.idx == '0) |=> reg0_r == $past(wr.data))
    else $error("register zero shadow missed a write");

endmodule

FILE: tb/sv/four_register_alu_executor_tb.sv
// Self-checking testbench for the four-register ALU executor, with a driver, monitor and predictor.
`timescale 1ns / 1ps

module four_register_alu_executor_tb;
  import fra_pkg::*;

  typedef struct packed {
    logic [OPC_W-1:0]     opcode;
    logic [IMM_W-1:0]     a;
    logic [IMM_W-1:0]     b;
    logic [REG_IDX_W-1:0] c;
  } alu_word_t;

  typedef struct packed {
    logic [DATA_W-1:0]    value;
    logic [REG_IDX_W-1:0] dest;
    logic [DATA_W-1:0]    reg0;
  } writeback_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [OPC_W-1:0]           in_opcode = '0;
  logic [IMM_W-1:0]           in_a = '0;
  logic [IMM_W-1:0]           in_b = '0;
  logic [REG_IDX_W-1:0]       in_c = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [DATA_W-1:0]   out_written_value;
  logic [REG_IDX_W-1:0]       out_dest_index;
  logic signed [DATA_W-1:0]   out_reg_zero;
  logic                       cfg_we = 1'b0;
  logic [MAP_W-1:0]           cfg_wdata = '0;

  // Predictor state: register file and opcode map as the block should hold them.
  logic [DATA_W-1:0] regfile [NUM_REGS];
  logic [MAP_W-1:0]  op_map = MAP_RESET;

  alu_word_t  instr_queue[$];
  writeback_t expected_writebacks[$];

  logic in_taken = 1'b0;
  int   queued_words = 0;
  int   accepted_words = 0;
  int   mismatches = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   hold_requests = 0;
  int   holds_served = 0;
  int   hold_left = 0;

  four_register_alu_executor uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opcode         (in_opcode),
    .in_a              (in_a),
    .in_b              (in_b),
    .in_c              (in_c),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_written_value (out_written_value),
    .out_dest_index    (out_dest_index),
    .out_reg_zero      (out_reg_zero),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Runs one instruction on the predicted register file and returns its write-back.
  function automatic writeback_t execute_word(alu_word_t w);
    logic [DATA_W-1:0]    ra;
    logic [DATA_W-1:0]    rb;
    logic [DATA_W-1:0]    ia;
    logic [DATA_W-1:0]    ib;
    logic [DATA_W-1:0]    r;
    logic [REG_IDX_W-1:0] dst;
    writeback_t           wb;
    ra  = regfile[w.a % NUM_REGS];
    rb  = regfile[w.b % NUM_REGS];
    ia  = DATA_W'(w.a);
    ib  = DATA_W'(w.b);
    dst = REG_IDX_W'(w.c % NUM_REGS);
    case (op_t'(op_map[w.opcode*OPC_W +: OPC_W]))
      OP_ADDR: r = ra + rb;
      OP_ADDI: r = ra + ib;
      OP_MULR: r = ra * rb;
      OP_MULI: r = ra * ib;
      OP_BANR: r = ra & rb;
      OP_BANI: r = ra & ib;
      OP_BORR: r = ra | rb;
      OP_BORI: r = ra | ib;
      OP_SETR: r = ra;
      OP_SETI: r = ia;
      // Immediates are at most 16 bits wide, so they are never negative as signed words.
      OP_GTIR: r = DATA_W'($signed(ia) > $signed(rb));
      OP_GTRI: r = DATA_W'($signed(ra) > $signed(ib));
      OP_GTRR: r = DATA_W'($signed(ra) > $signed(rb));
      OP_EQIR: r = DATA_W'(ia == rb);
      OP_EQRI: r = DATA_W'(ra == ib);
      default: r = DATA_W'(ra == rb);
    endcase
    regfile[dst] = r;
    wb.value = r;
    wb.dest  = dst;
    wb.reg0  = regfile[0];
    return wb;
  endfunction

  // Monitor and predictor: both act on the values present just before the rising edge.
  always @(posedge clk) begin
    writeback_t exp_wb;
    if (!rst_n) begin
      foreach (regfile[i]) regfile[i] = '0;
      op_map = MAP_RESET;
      in_taken <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_writebacks.size() == 0) begin
          $display("%0t: unexpected word: value %h dest %0d reg0 %h", $time,
                   out_written_value, out_dest_index, out_reg_zero);
          mismatches++;
        end else begin
          exp_wb = expected_writebacks.pop_front();
          if (out_written_value !== exp_wb.value) begin
            $display("%0t: written_value expected %h actual %h", $time,
                     exp_wb.value, out_written_value);
            mismatches++;
          end
          if (out_dest_index !== exp_wb.dest) begin
            $display("%0t: dest_index expected %0d actual %0d", $time,
                     exp_wb.dest, out_dest_index);
            mismatches++;
          end
          if (out_reg_zero !== exp_wb.reg0) begin
            $display("%0t: reg_zero expected %h actual %h", $time,
                     exp_wb.reg0, out_reg_zero);
            mismatches++;
          end
        end
      end
      if (cfg_we) op_map = cfg_wdata;
      in_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        accepted_words++;
        expected_writebacks.push_back(execute_word({in_opcode, in_a, in_b, in_c}));
      end
    end
  end

  // Driver: a new word is offered only once the previous one has been taken.
  always @(negedge clk) begin
    alu_word_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (instr_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        w = instr_queue.pop_front();
        in_valid  <= 1'b1;
        in_opcode <= w.opcode;
        in_a      <= w.a;
        in_b      <= w.b;
        in_c      <= w.c;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (holds_served != hold_requests) begin
      holds_served++;
      hold_left = 60;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic add_word(input logic [OPC_W-1:0] opcode, input logic [IMM_W-1:0] a,
                          input logic [IMM_W-1:0] b, input logic [REG_IDX_W-1:0] c);
    instr_queue.push_back({opcode, a, b, c});
    queued_words++;
  endtask

  // Small operands often, so that register forms, equalities and tiny values turn up.
  function automatic logic [IMM_W-1:0] pick_operand();
    if ($urandom_range(99) < 35) return IMM_W'($urandom_range(7));
    return IMM_W'($urandom);
  endfunction

  task automatic add_random_words(input int count);
    for (int i = 0; i < count; i++) begin
      add_word(OPC_W'($urandom_range(15)), pick_operand(), pick_operand(),
               REG_IDX_W'($urandom_range(NUM_REGS - 1)));
    end
  endtask

  // Returns once every queued word has been taken and every result checked.
  task automatic wait_idle();
    while (accepted_words != queued_words || expected_writebacks.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic run_phase(input logic [MAP_W-1:0] map, input int count, input int send_pct,
                           input int recv_pct, input bit long_hold, input bit mid_pause);
    wait_idle();
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    cfg_we    <= 1'b1;
    cfg_wdata <= map;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (mid_pause) begin
      add_random_words(count / 2);
      wait_idle();
      add_random_words(count - count / 2);
    end else begin
      add_random_words(count);
    end
    if (long_hold) hold_requests++;
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed words under the identity map: opcode n selects operation n.
    add_word(OP_SETI, 16'hFFFF, 16'hFFFF, 2'd1);
    add_word(OP_SETI, 16'h0000, 16'h1234, 2'd0);
    add_word(OP_MULR, 16'h0001, 16'hFFFD, 2'd2);  // r2 goes negative
    add_word(OP_MULI, 16'h0002, 16'hFFFF, 2'd3);  // product wraps
    add_word(OP_ADDR, 16'h0002, 16'h0002, 2'd0);
    add_word(OP_ADDI, 16'h0001, 16'hFFFF, 2'd3);
    add_word(OP_BANR, 16'h0003, 16'h0002, 2'd0);
    add_word(OP_BANI, 16'h0002, 16'hFFFF, 2'd3);
    add_word(OP_BORR, 16'h0001, 16'h0002, 2'd0);
    add_word(OP_BORI, 16'h0000, 16'h8000, 2'd3);
    add_word(OP_SETR, 16'hFFFE, 16'h5A5A, 2'd0);  // register index wraps to r2
    add_word(OP_GTIR, 16'h0000, 16'h0002, 2'd3);  // zero above a negative register
    add_word(OP_GTIR, 16'hFFFF, 16'h0001, 2'd3);
    add_word(OP_GTRI, 16'h0002, 16'h0000, 2'd3);
    add_word(OP_GTRI, 16'h0001, 16'hFFFE, 2'd3);
    add_word(OP_GTRR, 16'h0001, 16'h0002, 2'd3);
    add_word(OP_GTRR, 16'h0002, 16'h0001, 2'd3);
    add_word(OP_EQIR, 16'hFFFF, 16'h0001, 2'd3);
    add_word(OP_EQRI, 16'h0001, 16'hFFFF, 2'd3);
    add_word(OP_EQRR, 16'h0001, 16'h0001, 2'd3);
    add_word(OP_EQRR, 16'h0001, 16'h0002, 2'd0);
    add_word(OP_SETI, 16'h0000, 16'h0000, 2'd2);

    run_phase({$urandom, $urandom}, 150, 0, 0, 1'b1, 1'b0);
    run_phase('0, 60, 74, 0, 1'b0, 1'b0);
    run_phase('1, 60, 0, 74, 1'b0, 1'b0);
    run_phase(64'h0123_4567_89AB_CDEF, 150, 17, 17, 1'b0, 1'b0);
    run_phase({$urandom, $urandom}, 150, 74, 0, 1'b0, 1'b0);
    run_phase(MAP_RESET, 150, 0, 74, 1'b0, 1'b0);
    run_phase({$urandom, $urandom}, 180, 17, 17, 1'b0, 1'b1);

    wait_idle();
    repeat (8) @(negedge clk);
    if (mismatches == 0 && expected_writebacks.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
